[src/bis_pkg.sv]
`timescale 1ns / 1ps

package bis_pkg;

   // fixed field widths
   localparam int OP_W    = 2;
   localparam int ID_W    = 32;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;

   // default set size
   localparam int DEFAULT_CAPACITY = 16;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

endpackage

[src/bis_store.sv]
`timescale 1ns / 1ps

module bis_store
   import bis_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [ID_W-1:0]  rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [ID_W-1:0]  wr_data
);

   logic [ID_W-1:0] mem [CAPACITY];
   logic [ID_W-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bis_ctrl.sv]
`timescale 1ns / 1ps

module bis_ctrl
   import bis_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [ID_W-1:0]    req_ident,
   input  logic [SLOT_W-1:0]  req_slot_index,
   output logic               rsp_strobe,
   output logic               rsp_ok,
   output logic [ID_W-1:0]    rsp_slot_value,
   output logic               rsp_slot_valid,
   output logic [COUNT_W-1:0] rsp_count,
   output logic [IDX_W-1:0]   mem_rd_addr,
   input  logic [ID_W-1:0]    mem_rd_data,
   output logic               mem_wr_en,
   output logic [IDX_W-1:0]   mem_wr_addr,
   output logic [ID_W-1:0]    mem_wr_data
);

   localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ_WAIT,
      ST_DEL_MOVE
   } state_type;

   state_type        state_ff;
   op_type           op_ff;
   logic [ID_W-1:0]  ident_ff;
   logic [IDX_W-1:0] addr_ff;
   logic [IDX_W-1:0] pos_ff;
   logic [CNT_W-1:0] count_ff;
   logic             strobe_ff;
   logic             ok_ff;
   logic [ID_W-1:0]  slot_value_ff;
   logic             slot_valid_ff;

   op_type           req_op;
   logic             accept;
   logic             hit;
   logic             last;
   logic             slot_ok;
   logic [IDX_W-1:0] last_addr;
   logic             count_full;
   logic             count_zero;

   assign req_op     = op_type'(req_opcode);
   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign hit        = (mem_rd_data == ident_ff);
   assign last       = ((CNT_W'(addr_ff) + CNT_W'(1)) == count_ff);
   assign last_addr  = IDX_W'(count_ff - CNT_W'(1));
   assign count_full = (count_ff == CNT_W'(CAPACITY));
   assign count_zero = (count_ff == '0);
   assign slot_ok    = (CMP_W'(req_slot_index) < CMP_W'(count_ff));

   // memory address and write-back selection
   always_comb begin
      mem_rd_addr = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = IDX_W'(count_ff);
      mem_wr_data = ident_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_READ)) begin
               mem_rd_addr = IDX_W'(req_slot_index);
            end
            // add into an empty set needs no scan
            if (accept && (req_op == OP_ADD) && count_zero) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = '0;
               mem_wr_data = req_ident;
            end
         end
         ST_SCAN: begin
            if (hit && (op_ff == OP_DELETE)) begin
               mem_rd_addr = last_addr;
            end else begin
               mem_rd_addr = addr_ff + IDX_W'(1);
            end
            // append after a scan that found nothing
            if ((op_ff == OP_ADD) && last && !hit) begin
               mem_wr_en = 1'b1;
            end
         end
         ST_DEL_MOVE: begin
            // last entry moves into the freed slot
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_ff;
            mem_wr_data = mem_rd_data;
         end
         default: begin
         end
      endcase
   end

   // sequencer: state, count and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff         <= req_op;
                  ident_ff      <= req_ident;
                  addr_ff       <= '0;
                  ok_ff         <= 1'b0;
                  slot_value_ff <= '0;
                  slot_valid_ff <= 1'b0;
                  case (req_op)
                     OP_ADD: begin
                        if (count_full) begin
                           strobe_ff <= 1'b1;
                        end else if (count_zero) begin
                           count_ff  <= CNT_W'(1);
                           ok_ff     <= 1'b1;
                           strobe_ff <= 1'b1;
                        end else begin
                           state_ff <= ST_SCAN;
                        end
                     end
                     OP_DELETE, OP_QUERY: begin
                        if (count_zero) begin
                           strobe_ff <= 1'b1;
                        end else begin
                           state_ff <= ST_SCAN;
                        end
                     end
                     OP_READ: begin
                        if (slot_ok) begin
                           state_ff <= ST_READ_WAIT;
                        end else begin
                           strobe_ff <= 1'b1;
                        end
                     end
                     default: begin
                        strobe_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (hit) begin
                  case (op_ff)
                     OP_DELETE: begin
                        pos_ff   <= addr_ff;
                        state_ff <= ST_DEL_MOVE;
                     end
                     OP_QUERY: begin
                        ok_ff     <= 1'b1;
                        strobe_ff <= 1'b1;
                        state_ff  <= ST_IDLE;
                     end
                     default: begin
                        // add of an identifier already held
                        strobe_ff <= 1'b1;
                        state_ff  <= ST_IDLE;
                     end
                  endcase
               end else if (last) begin
                  if (op_ff == OP_ADD) begin
                     count_ff <= count_ff + CNT_W'(1);
                     ok_ff    <= 1'b1;
                  end
                  strobe_ff <= 1'b1;
                  state_ff  <= ST_IDLE;
               end else begin
                  addr_ff <= addr_ff + IDX_W'(1);
               end
            end
            ST_READ_WAIT: begin
               slot_value_ff <= mem_rd_data;
               slot_valid_ff <= 1'b1;
               strobe_ff     <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            ST_DEL_MOVE: begin
               count_ff  <= count_ff - CNT_W'(1);
               ok_ff     <= 1'b1;
               strobe_ff <= 1'b1;
               state_ff  <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_ok         = ok_ff;
   assign rsp_slot_value = slot_value_ff;
   assign rsp_slot_valid = slot_valid_ff;
   assign rsp_count      = COUNT_W'(count_ff);

endmodule

[src/bounded_id_set_core.sv]
`timescale 1ns / 1ps

// Fixed-capacity unordered set of 32-bit identifiers, packed in slots
// 0 .. count-1 of a single-port-write, registered-read memory. An item is
// taken when start is high and busy is low; its one result appears on the
// rsp_ ports for a single cycle with rsp_strobe high and cannot be held
// off, so it must be captured in that cycle. Add, delete and query scan the
// held entries one per cycle through the memory read port, with busy high
// for the scan; a delete that finds its entry then reads the last entry
// and moves it into the freed slot before busy falls. Read slot keeps busy
// high until its registered read returns; an add to a full or empty set, an
// operation on an empty set and a read beyond count finish with busy never
// rising. The result is presented in the first cycle with busy low again
// (the cycle after the item is taken when busy never rises), and a new item
// may be taken in that same cycle. The store needs no clearing after reset.
module bounded_id_set_core
   import bis_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [ID_W-1:0]    req_ident,
   input  logic [SLOT_W-1:0]  req_slot_index,
   output logic               rsp_strobe,
   output logic               rsp_ok,
   output logic [ID_W-1:0]    rsp_slot_value,
   output logic               rsp_slot_valid,
   output logic [COUNT_W-1:0] rsp_count
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [IDX_W-1:0] mem_rd_addr;
   logic [ID_W-1:0]  mem_rd_data;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [ID_W-1:0]  mem_wr_data;

   // scan and update sequencer
   bis_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_ident     (req_ident),
      .req_slot_index(req_slot_index),
      .rsp_strobe    (rsp_strobe),
      .rsp_ok        (rsp_ok),
      .rsp_slot_value(rsp_slot_value),
      .rsp_slot_valid(rsp_slot_valid),
      .rsp_count     (rsp_count),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data)
   );

   // entry store
   bis_store #(
      .CAPACITY(CAPACITY)
   ) u_store (
      .clock  (clock),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data)
   );

endmodule

[src/bis_checker.sv]
`timescale 1ns / 1ps

module bis_checker
   import bis_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic               rsp_ok,
   input logic [ID_W-1:0]    rsp_slot_value,
   input logic               rsp_slot_valid,
   input logic [COUNT_W-1:0] rsp_count
);

   // a result only follows an accepted item or a busy cycle
   a_strobe_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start && !busy) || $past(busy)))
      else $error("result without a pending item");

   // count moves only together with a result
   a_count_moves: assert property (@(posedge clock) disable iff (reset)
      !$stable(rsp_count) |-> rsp_strobe)
      else $error("count changed without a result");

   // count never exceeds the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((CAPACITY > 31) || (32'(rsp_count) <= 32'(CAPACITY))))
      else $error("count beyond capacity");

   // a result without a valid slot carries a zero slot value
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_slot_valid) |-> (rsp_slot_value == '0))
      else $error("slot value without a valid slot");

   // a slot read never reports ok
   a_slot_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_slot_valid) |-> !rsp_ok)
      else $error("ok set on a slot read");

endmodule

bind bounded_id_set_core bis_checker #(.CAPACITY(CAPACITY)) u_bis_checker (.*);

[bench/bounded_id_set_core_test.sv]
`timescale 1ns / 1ps

module bounded_id_set_core_test;
   import bis_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int PHASES        = 3;
   localparam int DRAIN_CYCLES  = 40;
   localparam int POOL_SIZE     = 32;

   typedef struct packed {
      logic               ok;
      logic [ID_W-1:0]    value;
      logic               valid;
      logic [COUNT_W-1:0] count;
   } set_result_type;

   typedef struct {
      op_type            op;
      logic [ID_W-1:0]   ident;
      logic [SLOT_W-1:0] slot;
      int                rep;
      bit                fixed;
      set_result_type    want;
   } stim_row_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [OP_W-1:0]    req_opcode = '0;
   logic [ID_W-1:0]    req_ident = '0;
   logic [SLOT_W-1:0]  req_slot_index = '0;
   logic               rsp_strobe;
   logic               rsp_ok;
   logic [ID_W-1:0]    rsp_slot_value;
   logic               rsp_slot_valid;
   logic [COUNT_W-1:0] rsp_count;

   bounded_id_set_core u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_ident      (req_ident),
      .req_slot_index (req_slot_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_ok         (rsp_ok),
      .rsp_slot_value (rsp_slot_value),
      .rsp_slot_valid (rsp_slot_valid),
      .rsp_count      (rsp_count)
   );

   // shadow copy of the set
   logic [ID_W-1:0] held_ids [DEFAULT_CAPACITY];
   int              held_count = 0;

   set_result_type  pending_results [$];
   stim_row_type    plan [$];
   logic [ID_W-1:0] id_pool [POOL_SIZE];

   int mismatches     = 0;
   int results_seen   = 0;
   int items_sent     = 0;
   int full_refusals  = 0;
   int reads_past_end = 0;
   int cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run-length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what, input logic [ID_W-1:0] got,
                                input logic [ID_W-1:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // apply one operation to the shadow set and return the response it implies
   function automatic set_result_type apply_set_op(op_type op, logic [ID_W-1:0] ident,
                                                   logic [SLOT_W-1:0] slot);
      set_result_type res;
      int             pos;
      res = '0;
      pos = -1;
      for (int i = 0; i < held_count; i++)
         if (pos < 0 && held_ids[i] == ident) pos = i;
      case (op)
         OP_ADD: begin
            if (held_count < DEFAULT_CAPACITY && pos < 0) begin
               held_ids[held_count] = ident;
               held_count++;
               res.ok = 1'b1;
            end
         end
         OP_DELETE: begin
            if (pos >= 0) begin
               held_count--;
               held_ids[pos] = held_ids[held_count];
               res.ok = 1'b1;
            end
         end
         OP_QUERY: res.ok = (pos >= 0);
         default: begin
            if (int'(slot) < held_count) begin
               res.value = held_ids[slot];
               res.valid = 1'b1;
            end
         end
      endcase
      res.count = COUNT_W'(held_count);
      return res;
   endfunction

   function automatic stim_row_type mk_row(op_type op, logic [ID_W-1:0] ident,
                                           logic [SLOT_W-1:0] slot, int rep, bit fixed,
                                           logic ok, logic [ID_W-1:0] value, logic valid,
                                           logic [COUNT_W-1:0] count);
      stim_row_type r;
      r.op         = op;
      r.ident      = ident;
      r.slot       = slot;
      r.rep        = rep;
      r.fixed      = fixed;
      r.want.ok    = ok;
      r.want.value = value;
      r.want.valid = valid;
      r.want.count = count;
      return r;
   endfunction

   // hand one item to the block, idling first at the given rate
   task automatic send_item(input op_type op, input logic [ID_W-1:0] ident,
                            input logic [SLOT_W-1:0] slot, input bit fixed,
                            input set_result_type want, input int idle_pct);
      set_result_type pred;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_ident      <= ident;
      req_slot_index <= slot;
      do @(posedge clock); while (busy);
      if (op == OP_ADD && held_count == DEFAULT_CAPACITY) full_refusals++;
      if (op == OP_READ && int'(slot) >= held_count) reads_past_end++;
      pred = apply_set_op(op, ident, slot);
      pending_results.push_back(fixed ? want : pred);
      items_sent++;
   endtask

   // pick an identifier: often one that is held, often from a small pool
   function automatic logic [ID_W-1:0] pick_ident();
      int r;
      r = $urandom_range(99);
      if (r < 40 && held_count > 0) return held_ids[$urandom_range(held_count - 1)];
      if (r < 85) return id_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // response checker
   always @(posedge clock) begin : check_rsp
      set_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("response with no item outstanding", rsp_slot_value, '0);
         end else begin
            want = pending_results.pop_front();
            results_seen++;
            if (rsp_ok !== want.ok) flag_mismatch("ok", ID_W'(rsp_ok), ID_W'(want.ok));
            if (rsp_slot_value !== want.value)
               flag_mismatch("slot_value", rsp_slot_value, want.value);
            if (rsp_slot_valid !== want.valid)
               flag_mismatch("slot_valid", ID_W'(rsp_slot_valid), ID_W'(want.valid));
            if (rsp_count !== want.count)
               flag_mismatch("count", ID_W'(rsp_count), ID_W'(want.count));
         end
      end
   end

   initial begin : stimulus
      int             idle_pct;
      bit             filling;
      int             r;
      op_type         op;
      op_type         tide_op;
      op_type         other_op;
      set_result_type none;

      none = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed rows: empty set, duplicates, fill to full, swap-in on delete
      plan.push_back(mk_row(OP_QUERY,  32'h0000_0000, 4'd0,  1, 1, 0, '0, 0, 5'd0));
      plan.push_back(mk_row(OP_DELETE, 32'h0000_0005, 4'd0,  1, 1, 0, '0, 0, 5'd0));
      plan.push_back(mk_row(OP_READ,   32'hFFFF_FFFF, 4'd0,  1, 1, 0, '0, 0, 5'd0));
      plan.push_back(mk_row(OP_ADD,    32'h0000_0000, 4'd15, 1, 1, 1, '0, 0, 5'd1));
      plan.push_back(mk_row(OP_ADD,    32'hFFFF_FFFF, 4'd0,  1, 1, 1, '0, 0, 5'd2));
      plan.push_back(mk_row(OP_ADD,    32'h0000_0000, 4'd0,  1, 1, 0, '0, 0, 5'd2));
      plan.push_back(mk_row(OP_READ,   32'h0000_0000, 4'd1,  1, 1, 0, 32'hFFFF_FFFF, 1,
                            5'd2));
      plan.push_back(mk_row(OP_ADD,    32'h0000_0100, 4'd0, 14, 0, 0, '0, 0, 5'd0));
      plan.push_back(mk_row(OP_ADD,    32'h1234_5678, 4'd0,  1, 1, 0, '0, 0, 5'd16));
      plan.push_back(mk_row(OP_READ,   32'h0000_0000, 4'd15, 1, 0, 0, '0, 0, 5'd0));
      plan.push_back(mk_row(OP_DELETE, 32'h0000_0000, 4'd0,  1, 1, 1, '0, 0, 5'd15));
      plan.push_back(mk_row(OP_READ,   32'h0000_0000, 4'd0,  1, 0, 0, '0, 0, 5'd0));
      plan.push_back(mk_row(OP_DELETE, 32'h0000_0000, 4'd0,  1, 1, 0, '0, 0, 5'd15));
      plan.push_back(mk_row(OP_READ,   32'h0000_0000, 4'd15, 1, 1, 0, '0, 0, 5'd15));

      foreach (plan[i])
         for (int k = 0; k < plan[i].rep; k++)
            send_item(plan[i].op, plan[i].ident + k, plan[i].slot, plan[i].fixed,
                      plan[i].want, 35);

      // random part: tides of adds and deletes between empty and full
      filling = 1'b1;
      for (int p = 0; p < PHASES; p++) begin
         idle_pct = (p == 0) ? 35 : (p == 1) ? 56 : 0;
         id_pool[0] = '0;
         id_pool[1] = '1;
         for (int j = 2; j < POOL_SIZE; j++) id_pool[j] = $urandom;
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            if (held_count == DEFAULT_CAPACITY) filling = 1'b0;
            if (held_count == 0) filling = 1'b1;
            tide_op  = filling ? OP_ADD : OP_DELETE;
            other_op = filling ? OP_DELETE : OP_ADD;
            r = $urandom_range(99);
            if (r < 55)      op = tide_op;
            else if (r < 70) op = other_op;
            else if (r < 85) op = OP_QUERY;
            else             op = OP_READ;
            send_item(op, pick_ident(), SLOT_W'($urandom_range(15)), 0, none, idle_pct);
         end
      end
      start <= 1'b0;

      // let every response arrive, then watch for strays
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         flag_mismatch("responses never arrived", ID_W'(pending_results.size()), '0);

      $display("sent %0d items over three pacing phases, %0d responses checked",
               items_sent, results_seen);
      $display("%0d adds refused on a full set, %0d reads past the count",
               full_refusals, reads_past_end);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
src/bis_pkg.sv
src/bis_store.sv
src/bis_ctrl.sv
src/bounded_id_set_core.sv
src/bis_checker.sv
bench/bounded_id_set_core_test.sv
